>>> sv/mmq_pkg.sv
package mmq_pkg;

   // Default store dimensions.
   localparam int MAX_ROWS_DEF  = 64;
   localparam int MAX_INNER_DEF = 64;
   localparam int MAX_COLS_DEF  = 64;

   // Field widths of the request and response words.
   localparam int KIND_W  = 2;
   localparam int IDX_W   = 6;
   localparam int ELEM_W  = 8;
   localparam int SUM_W   = 32;

   // Register file layout.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_W      = 7;
   localparam int OFS_W      = 9;

   // Operand and product widths of the multiply-accumulate unit.
   localparam int OPND_W = OFS_W + 1;
   localparam int PROD_W = 2 * OPND_W;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_B_OFFSET  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_C_OFFSET  = 3'd5;

   // Address width of a memory of the given depth.
   function automatic int addr_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

>>> sv/mmq_ram.sv
module mmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [mmq_pkg::addr_w(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [mmq_pkg::addr_w(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);
   import mmq_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/int8_matmul_with_zero_offsets.sv
// Load words give no response.
// A compute word works through the columns of its row in turn, with one shared
// multiply-accumulate unit fed one A and one B element per cycle from the two stores;
// with inner_len zero each column is posted without reads. A stalled response channel
// holds the sequencer. Requests are not taken while a row is computed.
// Synchronous active-high reset clears control state and resets configuration; stores are not cleared.
module int8_matmul_with_zero_offsets #(
   parameter int MAX_ROWS  = mmq_pkg::MAX_ROWS_DEF,
   parameter int MAX_INNER = mmq_pkg::MAX_INNER_DEF,
   parameter int MAX_COLS  = mmq_pkg::MAX_COLS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mmq_pkg::KIND_W-1:0]            req_kind,
   input  logic [mmq_pkg::IDX_W-1:0]             req_row,
   input  logic [mmq_pkg::IDX_W-1:0]             req_col,
   input  logic signed [mmq_pkg::ELEM_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mmq_pkg::SUM_W-1:0]      rsp_sum,
   output logic [mmq_pkg::IDX_W-1:0]             rsp_col_index,
   output logic                                  rsp_last,
   input  logic                                  csr_we,
   input  logic [mmq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mmq_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import mmq_pkg::*;

   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int AAW     = addr_w(A_DEPTH);
   localparam int BAW     = addr_w(B_DEPTH);
   // Inner counter holds values up to MAX_INNER itself.
   localparam int KCW     = $clog2(MAX_INNER + 1) + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_POST  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [DIM_W-1:0]        row_count_ff, inner_len_ff, col_count_ff;
   logic signed [OFS_W-1:0] a_off_ff, b_off_ff;
   logic [SUM_W-1:0]        c_off_ff;

   // Sequencer registers.
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  j_ff, j_in;
   logic [KCW-1:0]    k_ff, k_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              s1_vld_ff, s2_vld_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic [IDX_W-1:0]  rsp_col_ff;
   logic              rsp_last_ff;

   logic [KCW-1:0]    inner_eff;
   logic [DIM_W-1:0]  cols_eff;
   logic              req_take, issue, out_free, out_load, col_last;
   logic              a_wr_en, b_wr_en;
   logic [AAW-1:0]    a_wr_addr, a_rd_addr;
   logic [BAW-1:0]    b_wr_addr, b_rd_addr;
   logic [ELEM_W-1:0] a_rd_data, b_rd_data;
   logic signed [OPND_W-1:0] a_opnd, b_opnd;

   // Dimension registers saturate at the store dimensions.
   assign inner_eff = (int'(inner_len_ff) > MAX_INNER) ? KCW'(MAX_INNER) : KCW'(inner_len_ff);
   assign cols_eff  = (int'(col_count_ff) > MAX_COLS) ? DIM_W'(MAX_COLS) : col_count_ff;
   assign col_last  = (j_ff + DIM_W'(1)) == cols_eff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Element loads write the stores directly.
   assign a_wr_en   = req_take && (req_kind == KIND_LOAD_A) &&
                      (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_INNER);
   assign b_wr_en   = req_take && (req_kind == KIND_LOAD_B) &&
                      (int'(req_row) < MAX_INNER) && (int'(req_col) < MAX_COLS);
   assign a_wr_addr = AAW'(int'(req_row) * MAX_INNER + int'(req_col));
   assign b_wr_addr = BAW'(int'(req_row) * MAX_COLS + int'(req_col));

   // Read addresses walk the row of A and the column of B.
   assign issue     = (state_ff == ST_ISSUE);
   assign a_rd_addr = AAW'(int'(row_ff) * MAX_INNER + int'(k_ff));
   assign b_rd_addr = BAW'(int'(k_ff) * MAX_COLS + int'(j_ff));

   mmq_ram #(.WIDTH(ELEM_W), .DEPTH(A_DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mmq_ram #(.WIDTH(ELEM_W), .DEPTH(B_DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // Offset operands and the product, registered before accumulation.
   assign a_opnd  = OPND_W'(signed'(a_rd_data)) + OPND_W'(a_off_ff);
   assign b_opnd  = OPND_W'(signed'(b_rd_data)) + OPND_W'(b_off_ff);
   assign prod_in = a_opnd * b_opnd;

   // The response register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_POST) && out_free;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;

      if (s2_vld_ff) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_kind == KIND_COMPUTE) &&
                (int'(req_row) < MAX_ROWS) && (cols_eff != '0) &&
                (int'(row_count_ff) > int'(req_row))) begin
               row_in   = req_row;
               j_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               state_in = (inner_eff == '0) ? ST_POST : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            k_in = k_ff + KCW'(1);
            if ((k_ff + KCW'(1)) == inner_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (out_free) begin
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + DIM_W'(1);
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = (inner_eff == '0) ? ST_POST : ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Response valid sets on a new word and clears once taken.
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= issue;
         s2_vld_ff    <= s1_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      if (out_load) begin
         rsp_sum_ff  <= acc_ff + c_off_ff;
         rsp_col_ff  <= j_ff[IDX_W-1:0];
         rsp_last_ff <= col_last;
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_W'(64);
         inner_len_ff <= DIM_W'(64);
         col_count_ff <= DIM_W'(64);
         a_off_ff     <= '0;
         b_off_ff     <= '0;
         c_off_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[DIM_W-1:0];
            CSR_INNER_LEN: inner_len_ff <= csr_wdata[DIM_W-1:0];
            CSR_COL_COUNT: col_count_ff <= csr_wdata[DIM_W-1:0];
            CSR_A_OFFSET:  a_off_ff     <= signed'(csr_wdata[OFS_W-1:0]);
            CSR_B_OFFSET:  b_off_ff     <= signed'(csr_wdata[OFS_W-1:0]);
            CSR_C_OFFSET:  c_off_ff     <= csr_wdata[SUM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum       = signed'(rsp_sum_ff);
   assign rsp_col_index = rsp_col_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> verif/mmq_row_checker.sv
module mmq_row_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [mmq_pkg::KIND_W-1:0]           req_kind,
   input  logic [mmq_pkg::IDX_W-1:0]            req_row,
   input  logic [mmq_pkg::IDX_W-1:0]            req_col,
   input  logic signed [mmq_pkg::ELEM_W-1:0]    req_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [mmq_pkg::SUM_W-1:0]     rsp_sum,
   input  logic [mmq_pkg::IDX_W-1:0]            rsp_col_index,
   input  logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [mmq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mmq_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   fail_count,
   output int                                   pending
);
   import mmq_pkg::*;

   // One result word as it should appear on the response channel.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [IDX_W-1:0] col_index;
      logic             last;
   } col_result_type;

   // Private copies of both matrices and of the register file.
   logic signed [ELEM_W-1:0] a_mem [MAX_ROWS_DEF][MAX_INNER_DEF];
   logic signed [ELEM_W-1:0] b_mem [MAX_INNER_DEF][MAX_COLS_DEF];
   logic [DIM_W-1:0]         row_count_r;
   logic [DIM_W-1:0]         inner_len_r;
   logic [DIM_W-1:0]         col_count_r;
   logic signed [OFS_W-1:0]  a_ofs_r;
   logic signed [OFS_W-1:0]  b_ofs_r;
   logic [SUM_W-1:0]         c_ofs_r;

   col_result_type expected_cols[$];
   int mismatches = 0;

   assign fail_count = mismatches;

   // Dimension registers saturate at the store size.
   function automatic int clamp_dim(input int v, input int limit);
      return (v > limit) ? limit : v;
   endfunction

   // Work out every column of one result row and queue it.
   task automatic predict_row(input int row);
      int rows;
      int inner;
      int cols;
      int av;
      int bv;
      logic [SUM_W-1:0] acc;
      col_result_type res;
      rows  = clamp_dim(int'(row_count_r), MAX_ROWS_DEF);
      inner = clamp_dim(int'(inner_len_r), MAX_INNER_DEF);
      cols  = clamp_dim(int'(col_count_r), MAX_COLS_DEF);
      if (row >= rows || cols == 0) return;
      for (int j = 0; j < cols; j++) begin
         acc = '0;
         for (int k = 0; k < inner; k++) begin
            av  = int'(a_mem[row][k]) + int'(a_ofs_r);
            bv  = int'(b_mem[k][j]) + int'(b_ofs_r);
            acc = acc + SUM_W'(av * bv);
         end
         res.sum       = acc + c_ofs_r;
         res.col_index = IDX_W'(j);
         res.last      = (j + 1 == cols);
         expected_cols.push_back(res);
      end
   endtask

   // Compare one accepted result word against the oldest expectation.
   task automatic check_result();
      col_result_type want;
      if (expected_cols.size() == 0) begin
         $error("unexpected result word: sum %0d col_index %0d last %0b",
                rsp_sum, rsp_col_index, rsp_last);
         mismatches++;
         return;
      end
      want = expected_cols.pop_front();
      if (rsp_sum !== want.sum) begin
         $error("sum: expected %0d, actual %0d", $signed(want.sum), rsp_sum);
         mismatches++;
      end
      if (rsp_col_index !== want.col_index) begin
         $error("col_index: expected %0d, actual %0d", want.col_index, rsp_col_index);
         mismatches++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0b, actual %0b", want.last, rsp_last);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_count_r = DIM_W'(MAX_ROWS_DEF);
         inner_len_r = DIM_W'(MAX_INNER_DEF);
         col_count_r = DIM_W'(MAX_COLS_DEF);
         a_ofs_r     = '0;
         b_ofs_r     = '0;
         c_ofs_r     = '0;
         expected_cols.delete();
      end else begin
         // Register writes; each register keeps only its own width.
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_COUNT: row_count_r = csr_wdata[DIM_W-1:0];
               CSR_INNER_LEN: inner_len_r = csr_wdata[DIM_W-1:0];
               CSR_COL_COUNT: col_count_r = csr_wdata[DIM_W-1:0];
               CSR_A_OFFSET:  a_ofs_r     = csr_wdata[OFS_W-1:0];
               CSR_B_OFFSET:  b_ofs_r     = csr_wdata[OFS_W-1:0];
               CSR_C_OFFSET:  c_ofs_r     = csr_wdata[SUM_W-1:0];
               default: ;
            endcase
         end
         // Results are matched before a new row is queued behind them.
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) begin
            case (req_kind)
               KIND_LOAD_A:  a_mem[req_row][req_col] = req_value;
               KIND_LOAD_B:  b_mem[req_row][req_col] = req_value;
               KIND_COMPUTE: predict_row(int'(req_row));
               default: ;
            endcase
         end
      end
      pending <= expected_cols.size();
   end

endmodule

>>> verif/tb_int8_matmul_with_zero_offsets.sv
module tb_int8_matmul_with_zero_offsets;
   import mmq_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int IDLE_LIMIT      = 20000;
   localparam int HOLD_CYCLES     = 400;
   localparam int PHASES          = 6;
   localparam int HOLD_PHASE      = 2;
   localparam int ITEMS_PER_PHASE = 5;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [KIND_W-1:0]           req_kind = '0;
   logic [IDX_W-1:0]            req_row = '0;
   logic [IDX_W-1:0]            req_col = '0;
   logic signed [ELEM_W-1:0]    req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]     rsp_sum;
   logic [IDX_W-1:0]            rsp_col_index;
   logic                        rsp_last;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;
   int                          fail_count;
   int                          pending;

   // Stimulus-side bookkeeping: which entries hold data, and the dimensions in force.
   bit a_loaded [MAX_ROWS_DEF][MAX_INNER_DEF];
   bit b_loaded [MAX_INNER_DEF][MAX_COLS_DEF];
   int rows_e;
   int inner_e;
   int cols_e;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;
   int roll;
   int row;

   always #1 clock = ~clock;

   int8_matmul_with_zero_offsets dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum       (rsp_sum),
      .rsp_col_index (rsp_col_index),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   mmq_row_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum       (rsp_sum),
      .rsp_col_index (rsp_col_index),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // Result receiver: random stalls, or one long hold-off when asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 24);
      end
   end

   // Watchdog on cycles in which no word moves on any port.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int rand_elem();
      return int'($urandom_range(255)) - 128;
   endfunction

   // Row counts may be zero or oversized, since they cost no loads.
   function automatic int pick_rows();
      int r;
      r = int'($urandom_range(99));
      if (r < 5) return 0;
      if (r < 15) return int'($urandom_range(65, 127));
      if (r < 20) return 64;
      return int'($urandom_range(1, 8));
   endfunction

   // Inner and column counts stay small to keep the number of loads low.
   function automatic int pick_dim();
      int r;
      r = int'($urandom_range(99));
      if (r < 5) return 0;
      return int'($urandom_range(1, 4));
   endfunction

   function automatic int pick_ofs();
      return int'($urandom_range(511)) - 256;
   endfunction

   // Offer one request word, with a random gap in front, and wait until it is taken.
   task automatic send_word(input logic [KIND_W-1:0] kind, input int r, input int c,
                            input int value);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_row   <= IDX_W'(r);
      req_col   <= IDX_W'(c);
      req_value <= ELEM_W'(value);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_LOAD_A) a_loaded[r][c] = 1'b1;
      else if (kind == KIND_LOAD_B) b_loaded[r][c] = 1'b1;
   endtask

   // Load every entry the row will read that has never been written, then compute it.
   task automatic compute_row(input int r);
      if (r < rows_e && cols_e > 0) begin
         for (int k = 0; k < inner_e; k++)
            if (!a_loaded[r][k]) send_word(KIND_LOAD_A, r, k, rand_elem());
         for (int k = 0; k < inner_e; k++)
            for (int j = 0; j < cols_e; j++)
               if (!b_loaded[k][j]) send_word(KIND_LOAD_B, k, j, rand_elem());
      end
      send_word(KIND_COMPUTE, r, $urandom_range(63), rand_elem());
   endtask

   // Drain all expected results, then allow for a row still being worked on.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (cols_e * (inner_e + 4) + 16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_config(input int rows, input int inner, input int cols,
                               input int a_ofs, input int b_ofs,
                               input logic [SUM_W-1:0] c_ofs);
      write_reg(CSR_ROW_COUNT, CSR_DATA_W'(rows));
      write_reg(CSR_INNER_LEN, CSR_DATA_W'(inner));
      write_reg(CSR_COL_COUNT, CSR_DATA_W'(cols));
      write_reg(CSR_A_OFFSET, CSR_DATA_W'(a_ofs));
      write_reg(CSR_B_OFFSET, CSR_DATA_W'(b_ofs));
      write_reg(CSR_C_OFFSET, c_ofs);
      csr_we  <= 1'b0;
      rows_e  = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
      inner_e = (inner > MAX_INNER_DEF) ? MAX_INNER_DEF : inner;
      cols_e  = (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full row range with extreme elements and offsets; the fill runs without gaps.
      quiet <= 1'b1;
      write_config(64, 4, 4, -256, -256, 32'h7FFF_FFFF);
      send_word(KIND_LOAD_A, 0, 0, -128);
      send_word(KIND_LOAD_A, 63, 3, 127);
      send_word(KIND_LOAD_B, 0, 0, 127);
      send_word(KIND_LOAD_B, 3, 3, -128);
      send_word(KIND_UNUSED, 63, 63, -1);
      compute_row(63);
      compute_row(0);
      quiet <= 1'b0;
      settle();

      // Oversized row and column counts saturate; zero inner length gives the result offset.
      write_config(127, 0, 65, 255, 255, 32'h8000_0000);
      compute_row(5);
      compute_row(63);
      settle();

      // Rows at or above the row count give nothing.
      write_config(10, 2, 3, -1, 1, 32'hFFFF_FFFB);
      compute_row(10);
      compute_row(63);
      compute_row(9);
      settle();

      // Zero row count, then zero column count.
      write_config(0, 4, 3, 0, 0, '0);
      compute_row(0);
      settle();
      write_config(5, 3, 0, 0, 0, '0);
      compute_row(2);
      settle();

      // Smallest matrices with opposite extreme offsets.
      write_config(1, 1, 1, -256, 255, 32'hFFFF_FFFF);
      compute_row(0);
      compute_row(1);
      settle();

      // Random phases: mostly well-formed rows with random content and settings.
      for (int p = 0; p < PHASES; p++) begin
         if (p == HOLD_PHASE) begin
            // Stall the receiver for a long stretch while computes keep coming.
            write_config(4, 2, 8, pick_ofs(), pick_ofs(), $urandom());
            hold_off <= 1'b1;
            @(posedge clock);
            hold_off <= 1'b0;
            for (int n = 0; n < 5; n++) compute_row($urandom_range(3));
         end else begin
            write_config(pick_rows(), pick_dim(), pick_dim(), pick_ofs(), pick_ofs(),
                         $urandom());
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
               send_word(KIND_LOAD_A, $urandom_range(63), $urandom_range(63), rand_elem());
            end else if (roll < 55) begin
               send_word(KIND_LOAD_B, $urandom_range(63), $urandom_range(63), rand_elem());
            end else if (roll < 92) begin
               if (rows_e > 0 && $urandom_range(99) < 85) row = $urandom_range(rows_e - 1);
               else row = $urandom_range(63);
               compute_row(row);
            end else begin
               send_word(KIND_UNUSED, $urandom_range(63), $urandom_range(63), rand_elem());
            end
         end
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
